FILE: hdl/lpht_pkg.sv
// ============================================================================
// lpht_pkg - shared definitions for the linear probe hash table
// Table geometry, command and status codes, and the command beat that the
// front end hands to the probe engine through the command queue.
// ============================================================================
package lpht_pkg;

    localparam int TABLE_SIZE  = 13;
    localparam int KEY_WIDTH   = 16;
    localparam int SLOT_W      = $clog2(TABLE_SIZE);
    localparam int REM_W       = SLOT_W + 1;
    localparam int PROD_W      = 2 * KEY_WIDTH;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int FUNC_W      = 2;
    localparam int KEY_IN_W    = 16;
    localparam int SLOT_OUT_W  = 4;
    localparam int STATUS_W    = 2;

    // floor(2^KEY_WIDTH / TABLE_SIZE); the quotient estimate it yields is
    // never more than one below the true quotient.
    localparam logic [KEY_WIDTH-1:0] HOME_RECIP =
        KEY_WIDTH'((64'd1 << KEY_WIDTH) / TABLE_SIZE);

    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_INSERT,
        OP_SEARCH,
        OP_NOP
    } op_t;

    typedef logic [SLOT_W-1:0]    slot_t;
    typedef logic [KEY_WIDTH-1:0] tkey_t;

    typedef struct packed {
        op_t   op;
        tkey_t key;
        slot_t home;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_beat_t;

endpackage

FILE: hdl/lpht_front.sv
// ============================================================================
// lpht_front - command intake and home slot computation
// Takes input beats, decodes the function code and reduces the key modulo
// the table size with a reciprocal multiply, then offers the command to
// the command queue.
// ============================================================================
module lpht_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [lpht_pkg::FUNC_W-1:0]   func,
    input  logic [lpht_pkg::KEY_IN_W-1:0] key,
    output lpht_pkg::cmd_beat_t           cmd_out,
    input  logic                          q_full
);
    import lpht_pkg::*;

    logic              a_valid_reg, a_valid_next;
    op_t               a_op_reg;
    tkey_t             a_key_reg;
    logic [PROD_W-1:0] a_prod_reg;

    logic              accept;
    op_t               dec_op;
    tkey_t             key_k;
    tkey_t             q_est;
    tkey_t             rem_full;
    logic [REM_W-1:0]  rem;
    slot_t             home;

    assign full   = a_valid_reg && q_full;
    assign accept = push && !full;
    assign key_k  = KEY_WIDTH'(key);

    always_comb
    begin
        unique case (func)
            FUNC_CLEAR:  dec_op = OP_CLEAR;
            FUNC_INSERT: dec_op = OP_INSERT;
            FUNC_SEARCH: dec_op = OP_SEARCH;
            default:     dec_op = OP_NOP;
        endcase
    end

    // The estimate is the quotient or one less, so the remainder stays
    // below twice the table size and one conditional subtract fixes it.
    always_comb
    begin
        q_est    = a_prod_reg[PROD_W-1:KEY_WIDTH];
        rem_full = a_key_reg - KEY_WIDTH'(q_est * TABLE_SIZE);
        rem      = REM_W'(rem_full);
        if (rem >= REM_W'(TABLE_SIZE))
        begin
            home = SLOT_W'(rem - REM_W'(TABLE_SIZE));
        end
        else
        begin
            home = SLOT_W'(rem);
        end
    end

    assign a_valid_next = accept || (a_valid_reg && q_full);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_op_reg   <= dec_op;
            a_key_reg  <= key_k;
            a_prod_reg <= PROD_W'(key_k) * PROD_W'(HOME_RECIP);
        end
    end

    assign cmd_out.valid    = a_valid_reg;
    assign cmd_out.cmd.op   = a_op_reg;
    assign cmd_out.cmd.key  = a_key_reg;
    assign cmd_out.cmd.home = home;

endmodule

FILE: hdl/lpht_cmd_queue.sv
// ============================================================================
// lpht_cmd_queue - short command queue
// Decouples the front end from the probe engine so that each side can
// stall on its own.
// ============================================================================
module lpht_cmd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  lpht_pkg::cmd_beat_t wr_beat,
    output logic                q_full,
    output lpht_pkg::cmd_beat_t rd_beat,
    input  logic                rd_take
);
    import lpht_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    logic do_wr;
    logic do_rd;

    assign q_full        = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign do_wr         = wr_beat.valid && !q_full;
    assign do_rd         = rd_take && (count_reg != '0);
    assign rd_beat.valid = (count_reg != '0);
    assign rd_beat.cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_beat.cmd;
        end
    end

endmodule

FILE: hdl/lpht_probe.sv
// ============================================================================
// lpht_probe - probe engine and slot storage
// Holds the key memory and the occupancy bits, walks the probe sequence one
// slot per cycle and keeps the result in an output register.
// ============================================================================
module lpht_probe (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lpht_pkg::cmd_beat_t             cmd_in,
    output logic                            cmd_take,
    output logic                            empty,
    input  logic                            pop,
    output logic [lpht_pkg::SLOT_OUT_W-1:0] slot_index,
    output logic [lpht_pkg::STATUS_W-1:0]   status
);
    import lpht_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_PROBE
    } state_t;

    state_t                  state_reg, state_next;
    op_t                     op_reg, op_next;
    tkey_t                   key_reg, key_next;
    slot_t                   pos_reg, pos_next;
    slot_t                   cnt_reg, cnt_next;
    logic [TABLE_SIZE-1:0]   used_reg, used_next;
    logic                    out_valid_reg, out_valid_next;
    logic [SLOT_OUT_W-1:0]   out_slot_reg, out_slot_next;
    logic [STATUS_W-1:0]     out_status_reg, out_status_next;

    tkey_t                   slot_keys [TABLE_SIZE];
    tkey_t                   rd_data_reg;
    slot_t                   rd_addr;
    logic                    wr_en;

    logic                    out_free;
    logic                    slot_empty;
    logic                    last_slot;
    slot_t                   pos_inc;

    assign out_free   = !out_valid_reg || pop;
    assign cmd_take   = (state_reg == S_IDLE) && cmd_in.valid && out_free;
    assign slot_empty = !used_reg[pos_reg];
    assign last_slot  = (cnt_reg == SLOT_W'(TABLE_SIZE - 1));
    assign pos_inc    = (pos_reg == SLOT_W'(TABLE_SIZE - 1)) ? '0 : pos_reg + 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        pos_next        = pos_reg;
        cnt_next        = cnt_reg;
        used_next       = used_reg;
        out_valid_next  = out_valid_reg && !pop;
        out_slot_next   = out_slot_reg;
        out_status_next = out_status_reg;
        rd_addr         = pos_reg;
        wr_en           = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_take)
                begin
                    case (cmd_in.cmd.op)
                        OP_INSERT, OP_SEARCH:
                        begin
                            op_next    = cmd_in.cmd.op;
                            key_next   = cmd_in.cmd.key;
                            pos_next   = cmd_in.cmd.home;
                            cnt_next   = '0;
                            rd_addr    = cmd_in.cmd.home;
                            state_next = S_PROBE;
                        end
                        OP_CLEAR:
                        begin
                            used_next       = '0;
                            out_valid_next  = 1'b1;
                            out_slot_next   = '0;
                            out_status_next = STATUS_DONE;
                        end
                        default:
                        begin
                            out_valid_next  = 1'b1;
                            out_slot_next   = '0;
                            out_status_next = STATUS_DONE;
                        end
                    endcase
                end
            end
            S_PROBE:
            begin
                // The output register was free at dispatch and nothing else
                // writes it during a probe, so a finishing probe always lands.
                if (op_reg == OP_INSERT)
                begin
                    if (slot_empty)
                    begin
                        used_next[pos_reg] = 1'b1;
                        wr_en              = 1'b1;
                        out_valid_next     = 1'b1;
                        out_slot_next      = SLOT_OUT_W'(pos_reg);
                        out_status_next    = STATUS_DONE;
                        state_next         = S_IDLE;
                    end
                    else if (last_slot)
                    begin
                        out_valid_next  = 1'b1;
                        out_slot_next   = '0;
                        out_status_next = STATUS_FULL;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        pos_next = pos_inc;
                        cnt_next = cnt_reg + 1'b1;
                        rd_addr  = pos_inc;
                    end
                end
                else
                begin
                    if (slot_empty || (last_slot && rd_data_reg != key_reg))
                    begin
                        out_valid_next  = 1'b1;
                        out_slot_next   = '0;
                        out_status_next = STATUS_MISS;
                        state_next      = S_IDLE;
                    end
                    else if (rd_data_reg == key_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_slot_next   = SLOT_OUT_W'(pos_reg);
                        out_status_next = STATUS_DONE;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        pos_next = pos_inc;
                        cnt_next = cnt_reg + 1'b1;
                        rd_addr  = pos_inc;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            out_valid_reg  <= 1'b0;
            op_reg         <= OP_NOP;
            key_reg        <= '0;
            pos_reg        <= '0;
            cnt_reg        <= '0;
            out_slot_reg   <= '0;
            out_status_reg <= STATUS_DONE;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            out_valid_reg  <= out_valid_next;
            op_reg         <= op_next;
            key_reg        <= key_next;
            pos_reg        <= pos_next;
            cnt_reg        <= cnt_next;
            out_slot_reg   <= out_slot_next;
            out_status_reg <= out_status_next;
        end
    end

    // Key storage: one write and one registered read per cycle. The read
    // address runs one slot ahead so the data meets the slot under test.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_keys[pos_reg] <= key_reg;
        end
        rd_data_reg <= slot_keys[rd_addr];
    end

    assign empty      = !out_valid_reg;
    assign slot_index = out_slot_reg;
    assign status     = out_status_reg;

endmodule

FILE: hdl/linear_probe_hash_table_unit.sv
// ============================================================================
// linear_probe_hash_table_unit - open addressing hash table, linear probing
// Usage notes:
//   Commands enter through a queue-style port: a beat is taken at a clock
//   edge where push is high and full is low. func selects clear, insert or
//   search; key is the lookup key (its home slot is key modulo 13).
//   Every command yields exactly one result beat on a queue-style port:
//   while empty is low, slot_index and status show the oldest result, and
//   it is taken at an edge where pop is high.
//   A command passes the intake register and the command queue before the
//   probe engine takes it; a clear or an unused code sets its result as it
//   is taken. Insert and search walk the table one slot per cycle through
//   the single key memory read port, probing 1 to 13 slots.
//   The probe engine takes no new command until the previous probe ends;
//   clears can follow every cycle as long as each result is popped as it
//   appears.
//   A two-entry command queue sits between intake and probe engine, so
//   commands are still taken while a result waits. If pop stays low, the
//   engine holds after finishing one result and full rises once the queue
//   and the intake stage fill.
//   Reset empties the table and all queues; no clearing pass is needed.
// ============================================================================
module linear_probe_hash_table_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [lpht_pkg::FUNC_W-1:0]     func,
    input  logic [lpht_pkg::KEY_IN_W-1:0]   key,
    output logic                            empty,
    input  logic                            pop,
    output logic [lpht_pkg::SLOT_OUT_W-1:0] slot_index,
    output logic [lpht_pkg::STATUS_W-1:0]   status
);
    import lpht_pkg::*;

    cmd_beat_t front_beat;
    cmd_beat_t queue_beat;
    logic      q_full;
    logic      cmd_take;

    lpht_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .func    (func),
        .key     (key),
        .cmd_out (front_beat),
        .q_full  (q_full)
    );

    lpht_cmd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_beat (front_beat),
        .q_full  (q_full),
        .rd_beat (queue_beat),
        .rd_take (cmd_take)
    );

    lpht_probe u_probe (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_in     (queue_beat),
        .cmd_take   (cmd_take),
        .empty      (empty),
        .pop        (pop),
        .slot_index (slot_index),
        .status     (status)
    );

    a_status_code : assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (status == STATUS_DONE || status == STATUS_MISS ||
                    status == STATUS_FULL))
        else $error("result carries an undefined status code");

    a_fail_slot_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != STATUS_DONE) |-> (slot_index == '0))
        else $error("miss or full result with a nonzero slot");

    a_front_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (front_beat.valid && q_full) |=> front_beat.valid)
        else $error("intake stage dropped a command while the queue was full");

    a_take_needs_cmd : assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> queue_beat.valid)
        else $error("probe engine took a command from an empty queue");

endmodule
